[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry layout, command bundle for the cell chain, operation and error codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH       = 16;
    localparam int PRIO_BITS   = 16;
    localparam int VALUE_BITS  = 32;
    localparam int IN_PRIO_W   = 16;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 64;
    localparam int OUT_USER_W  = 5;

    localparam logic       OP_PUSH   = 1'b0;
    localparam logic       OP_POP    = 1'b1;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic                  occ;
        logic [PRIO_BITS-1:0]  prio;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef struct packed {
        logic   push;   // insert new entry, chain not full
        logic   pop;    // shift toward front, chain not empty
        entry_t ins;    // entry being inserted
    } cmd_t;

    localparam entry_t ENTRY_EMPTY = '0;

endpackage

[design/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted register chain
// Holds one entry; on push keeps, takes the new entry or takes the left
// neighbor; on pop takes the right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  cmd_t   cmd,
    input  entry_t left_entry,
    input  logic   left_keep,
    input  entry_t right_entry,
    output entry_t entry,
    output logic   keep,
    output entry_t entry_next
);

    entry_t entry_reg;

    // entry stays in place when it sorts strictly ahead of the new one
    assign keep  = entry_reg.occ && (entry_reg.prio < cmd.ins.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.push) begin
            if (keep) begin
                entry_next = entry_reg;
            end else if (left_keep) begin
                entry_next = cmd.ins;
            end else begin
                entry_next = left_entry;
            end
        end else if (cmd.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= ENTRY_EMPTY;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

[design/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded min-priority queue on a sorted cell chain
// The result of each accepted item is registered and shown in the cycle after.
// One item per cycle while the result side does not stall; every cell compares
// against the new priority in parallel, so the whole chain updates at once.
// Reset: synchronous active-low aresetn empties all cells and the output.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // item_value[31:0], item_priority[47:32]
    input  logic                  s_axis_tuser,  // operation
    // result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // popped_value[31:0], front_value[63:32]
    output logic [OUT_USER_W-1:0] m_axis_tuser   // popped_valid, is_empty, is_full,
                                                 // error_code[4:3]
);

    // input fields
    logic                  in_op;
    logic [VALUE_BITS-1:0] in_value;
    logic [IN_PRIO_W-1:0]  in_prio;

    assign in_op    = s_axis_tuser;
    assign in_value = s_axis_tdata[VALUE_BITS-1:0];
    assign in_prio  = s_axis_tdata[VALUE_BITS +: IN_PRIO_W];

    // chain taps
    entry_t cell_q    [DEPTH];
    entry_t cell_next [DEPTH];
    logic   cell_keep [DEPTH];

    logic   accept;
    logic   is_full_now;
    logic   is_empty_now;
    cmd_t   cmd;

    // result register
    logic                  out_valid_reg,  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg,   out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg,   out_user_next;

    // output register frees up as soon as its item is taken
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // slots fill from the front, so the ends give the flags
    assign is_full_now  = cell_q[DEPTH-1].occ;
    assign is_empty_now = !cell_q[0].occ;

    // command broadcast to every cell
    always_comb begin
        cmd.push      = accept && (in_op == OP_PUSH) && !is_full_now;
        cmd.pop       = accept && (in_op == OP_POP) && !is_empty_now;
        cmd.ins.occ   = 1'b1;
        cmd.ins.prio  = in_prio[PRIO_BITS-1:0];
        cmd.ins.value = in_value;
    end

    // cell chain: left of the front acts as a keeping cell, right of the
    // tail feeds an empty entry so a vacated slot clears
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_k;

        if (i == 0) begin : g_front
            assign left_e = ENTRY_EMPTY;
            assign left_k = 1'b1;
        end else begin : g_mid
            assign left_e = cell_q[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == DEPTH-1) begin : g_tail
            assign right_e = ENTRY_EMPTY;
        end else begin : g_body
            assign right_e = cell_q[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .entry       (cell_q[i]),
            .keep        (cell_keep[i]),
            .entry_next  (cell_next[i])
        );
    end

    // result of the accepted item, taken from the chain's next state
    always_comb begin
        logic [VALUE_BITS-1:0] popped;
        logic                  pvalid;
        logic [1:0]            err;
        logic [VALUE_BITS-1:0] front;

        popped = '0;
        pvalid = 1'b0;
        err    = ERR_OK;
        if (in_op == OP_PUSH) begin
            if (is_full_now) begin
                err = ERR_FULL;
            end
        end else begin
            if (is_empty_now) begin
                err = ERR_EMPTY;
            end else begin
                popped = cell_q[0].value;
                pvalid = 1'b1;
            end
        end
        // empty slots hold zero, but mask anyway on the empty case
        front = cell_next[0].occ ? cell_next[0].value : '0;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_data_next  = {front, popped};
            out_user_next  = {err, cell_next[DEPTH-1].occ, !cell_next[0].occ, pvalid};
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

[tb/sv/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// A mirror of the sorted slot chain predicts every result from the accepted
// items. Both stream sides are driven with random idle gaps and stalls.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue
    import spq_pkg::*;
();

    // expected contents of one result item
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] popped_value;
        logic                         popped_valid;
        logic signed [VALUE_BITS-1:0] front_value;
        logic                         is_empty;
        logic                         is_full;
        logic [1:0]                   error_code;
    } queue_result_t;

    // mirror of the slot chain plus the results still owed by the block
    class sorted_queue_mirror;
        logic signed [VALUE_BITS-1:0] slot_value [DEPTH];
        logic [PRIO_BITS-1:0]         slot_prio  [DEPTH];
        int unsigned                  held;
        queue_result_t                expected_results [$];

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                slot_value[i] = '0;
                slot_prio[i]  = '0;
            end
            held = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // advance the mirror by one accepted item and queue its result
        function void apply_item(logic op, logic [VALUE_BITS-1:0] val,
                                 logic [IN_PRIO_W-1:0] prio_in);
            queue_result_t        res;
            logic [PRIO_BITS-1:0] prio;
            int unsigned          pos;
            res  = '0;
            prio = prio_in[PRIO_BITS-1:0];
            if (op == OP_PUSH) begin
                if (held >= DEPTH) begin
                    res.error_code = ERR_FULL;
                end else begin
                    // new entry goes ahead of equal priorities
                    pos = 0;
                    while (pos < held && slot_prio[pos] < prio)
                        pos++;
                    for (int i = held; i > pos; i--) begin
                        slot_value[i] = slot_value[i-1];
                        slot_prio[i]  = slot_prio[i-1];
                    end
                    slot_value[pos] = val;
                    slot_prio[pos]  = prio;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    res.error_code = ERR_EMPTY;
                end else begin
                    res.popped_value = slot_value[0];
                    res.popped_valid = 1'b1;
                    for (int i = 0; i + 1 < held; i++) begin
                        slot_value[i] = slot_value[i+1];
                        slot_prio[i]  = slot_prio[i+1];
                    end
                    held--;
                    slot_value[held] = '0;
                    slot_prio[held]  = '0;
                end
            end
            res.front_value = (held != 0) ? slot_value[0] : '0;
            res.is_empty    = (held == 0);
            res.is_full     = (held >= DEPTH);
            expected_results.push_back(res);
        endfunction

        // compare one result item with the oldest expectation, "" when it matches
        function string match_result(logic [OUT_DATA_W-1:0] tdata,
                                     logic [OUT_USER_W-1:0] tuser);
            queue_result_t exp_res;
            queue_result_t got;
            string         diff;
            if (expected_results.size() == 0)
                return $sformatf("result with no item pending: tdata=%h tuser=%b",
                                 tdata, tuser);
            exp_res          = expected_results.pop_front();
            got.popped_value = tdata[31:0];
            got.front_value  = tdata[63:32];
            got.popped_valid = tuser[0];
            got.is_empty     = tuser[1];
            got.is_full      = tuser[2];
            got.error_code   = tuser[4:3];
            diff = "";
            if (got.popped_value !== exp_res.popped_value)
                diff = {diff, $sformatf(" popped_value %h/%h",
                                        got.popped_value, exp_res.popped_value)};
            if (got.popped_valid !== exp_res.popped_valid)
                diff = {diff, $sformatf(" popped_valid %b/%b",
                                        got.popped_valid, exp_res.popped_valid)};
            if (got.front_value !== exp_res.front_value)
                diff = {diff, $sformatf(" front_value %h/%h",
                                        got.front_value, exp_res.front_value)};
            if (got.is_empty !== exp_res.is_empty)
                diff = {diff, $sformatf(" is_empty %b/%b",
                                        got.is_empty, exp_res.is_empty)};
            if (got.is_full !== exp_res.is_full)
                diff = {diff, $sformatf(" is_full %b/%b",
                                        got.is_full, exp_res.is_full)};
            if (got.error_code !== exp_res.error_code)
                diff = {diff, $sformatf(" error_code %0d/%0d",
                                        got.error_code, exp_res.error_code)};
            if (diff != "")
                diff = {"result mismatch (got/exp):", diff};
            return diff;
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1430;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // item_value[31:0], item_priority[47:32]
    logic                  s_axis_tuser  = OP_PUSH;  // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // popped_value[31:0], front_value[63:32]
    logic [OUT_USER_W-1:0] m_axis_tuser;   // popped_valid, is_empty, is_full,
                                           // error_code[4:3]

    // idle enables, switched per stretch of the random part
    logic tx_idle_en = 1'b0;
    logic rx_idle_en = 1'b0;
    int   rx_hold    = 0;
    int   mismatch_count = 0;

    sorted_queue_mirror mirror = new();

    sorted_priority_queue u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 aclk = ~aclk;

    // mostly no gap, some short gaps, a few long ones
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR %s", $realtime, msg);
        mismatch_count++;
    endtask

    // present one item at a falling edge and hold it until it is taken
    task automatic send_item(input logic op, input logic [VALUE_BITS-1:0] val,
                             input logic [IN_PRIO_W-1:0] prio);
        int gap;
        gap = tx_idle_en ? idle_span() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            // idle cycles carry junk on the data lines
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = IN_DATA_W'({$urandom, $urandom});
            s_axis_tuser  = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {prio, val};
        s_axis_tuser  = op;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // result side backpressure, updated at falling edges
    always @(negedge aclk) begin
        if (!rx_idle_en) begin
            m_axis_tready = 1'b1;
            rx_hold       = 0;
        end else if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else begin
            rx_hold = idle_span();
            if (rx_hold > 0) begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // accepted items feed the mirror first, then any result is checked
    always @(posedge aclk) begin : watch_ports
        string verdict;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                mirror.apply_item(s_axis_tuser, s_axis_tdata[31:0],
                                  s_axis_tdata[47:32]);
            if (m_axis_tvalid && m_axis_tready) begin
                verdict = mirror.match_result(m_axis_tdata, m_axis_tuser);
                if (verdict != "")
                    report_mismatch(verdict);
            end
        end
    end

    initial begin : stimulus
        // directed fill: extremes of value and priority, ties, full range
        logic [VALUE_BITS-1:0] fill_value [16] = '{
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
            32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
            32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_0000,
            32'h0000_FFFF, 32'hDEAD_0001, 32'h00C0_FFEE, 32'h3C3C_C3C3};
        logic [IN_PRIO_W-1:0]  fill_prio [16] = '{
            16'hFFFF, 16'h0000, 16'h0000, 16'h8000,
            16'h7FFF, 16'h0001, 16'hFFFE, 16'h0005,
            16'h0005, 16'h0005, 16'h1234, 16'hFFFF,
            16'h0000, 16'h00FF, 16'hFF00, 16'h5555};
        int                    stretch;
        int                    push_bias;
        int                    mode;
        int                    sent;
        int                    r;
        logic                  op;
        logic [VALUE_BITS-1:0] val;
        logic [IN_PRIO_W-1:0]  prio;

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // pop on an empty queue
        send_item(OP_POP, 32'hFFFF_FFFF, 16'hFFFF);
        // fill to the top with the receiver stalling at random
        rx_idle_en = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            send_item(OP_PUSH, fill_value[i], fill_prio[i]);
        // push on a full queue is dropped
        send_item(OP_PUSH, 32'h1111_1111, 16'h0000);
        // pops return the newest of the lowest priorities first
        for (int i = 0; i < 4; i++)
            send_item(OP_POP, 32'h0, 16'h0);

        // random part: stretches that lean toward push or pop so the
        // queue keeps swinging between empty and full
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            stretch = $urandom_range(20, 60);
            r = $urandom_range(0, 2);
            push_bias = (r == 0) ? 85 : (r == 1) ? 50 : 15;
            mode = $urandom_range(0, 3);
            tx_idle_en = mode[0];
            rx_idle_en = mode[1];
            for (int k = 0; k < stretch && sent < RANDOM_ITEMS; k++) begin
                op  = ($urandom_range(0, 99) < push_bias) ? OP_PUSH : OP_POP;
                val = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    r = $urandom_range(0, 3);
                    val = (r == 0) ? 32'h7FFF_FFFF : (r == 1) ? 32'h8000_0000 :
                          (r == 2) ? 32'hFFFF_FFFF : 32'h0;
                end
                r = $urandom_range(0, 99);
                if (r < 40)
                    prio = IN_PRIO_W'($urandom);
                else if (r < 70)
                    prio = IN_PRIO_W'($urandom_range(0, 3));  // crowd of ties
                else if (r < 80)
                    prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    prio = IN_PRIO_W'($urandom_range(16'h7FF0, 16'h800F));
                send_item(op, val, prio);
                sent++;
            end
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b0;

        // drain, then wait in quiet for anything unexpected
        while (mirror.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit well past the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sorted_priority_queue.f]
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
